/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL top level; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

/* rtl/core/fic_pkg.sv */
// Shared constants and controller/datapath signal groups of the file ID compactor.
`timescale 1ns / 1ps

package fic_pkg;

  // Inode counter wraps when it would reach the limit and restarts at two.
  localparam logic [15:0] INO_LIMIT   = 16'hffff;
  localparam logic [15:0] INO_RESTART = 16'd2;

  // Bucket hash: (dev ^ ino) mod 103, done as a multiply by floor(2^38 / 103)
  // followed by one correcting subtraction.
  localparam int          HASH_MOD   = 103;
  localparam logic [31:0] HASH_RECIP = 32'd2668717543;
  localparam int          HASH_SHIFT = 38;

  // One table entry: 64-bit key above a 32-bit compact pair.
  localparam int KEY_W  = 64;
  localparam int PAIR_W = 32;
  localparam int ENT_W  = KEY_W + PAIR_W;

  typedef struct packed {
    logic load;      // capture the input item
    logic clr_step;  // clear one bucket fill count
    logic fill_rd;   // read the bucket fill count
    logic fill_cap;  // capture the fill count, restart the way scan
    logic way_rd;    // read the current way
    logic way_cmp;   // compare the way read last cycle
    logic finish;    // load the result register and update the table
  } fic_cmd_t;

  typedef struct packed {
    logic multi_in;   // the offered item has two or more links
    logic clr_last;   // clearing the last bucket
    logic ways_done;  // every filled way of the bucket has been compared
    logic key_match;  // the way read last cycle holds the key
  } fic_sts_t;

endpackage

/* rtl/core/fic_ifs.sv */
// Valid/ready channel interfaces for the input items and the results.
`timescale 1ns / 1ps

interface fic_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] link_count;
  logic [31:0] long_dev;
  logic [31:0] long_ino;

  modport source (output valid, link_count, long_dev, long_ino, input ready);
  modport sink   (input valid, link_count, long_dev, long_ino, output ready);
endinterface

interface fic_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] short_dev;
  logic [15:0] short_ino;
  logic        seen_before;
  logic        status;

  modport source (output valid, short_dev, short_ino, seen_before, status, input ready);
  modport sink   (input valid, short_dev, short_ino, seen_before, status, output ready);
endinterface

/* rtl/core/fic_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module fic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/fic_dp.sv */
// Datapath: pair counters, bucket hash, way scan and the table memories.
`timescale 1ns / 1ps

module fic_dp #(
  parameter int BUCKETS = 128,
  parameter int WAYS    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      link_count,
  input  logic [31:0]      long_dev,
  input  logic [31:0]      long_ino,
  input  fic_pkg::fic_cmd_t cmd,
  output fic_pkg::fic_sts_t sts,
  output logic [15:0]      short_dev,
  output logic [15:0]      short_ino,
  output logic             seen_before,
  output logic             status
);
  import fic_pkg::*;

  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int CNT_W     = $clog2(WAYS + 1);
  localparam int ENT_AW    = $clog2(BUCKETS * WAYS);
  localparam int RED_STEPS = (BUCKETS > HASH_MOD - 1) ? 0 : (HASH_MOD - 1) / BUCKETS;

  // Captured item.
  logic [31:0] dev_r, ino_r;
  logic        multi_r;

  // Hash pipeline, free running on the captured key.
  logic [63:0] prod_r;
  logic [7:0]  rraw_r;
  logic [BKT_W-1:0] bucket_r;
  logic [31:0] hash_x;
  logic [15:0] qm_full;
  logic [6:0]  red;
  logic [BKT_W-1:0] bucket_nxt;

  // Way scan.
  logic [CNT_W-1:0] fill_r, way_r, clr_dummy;
  logic [BKT_W-1:0] clr_idx_r;
  logic             hit_r;
  logic [PAIR_W-1:0] hit_pair_r;
  logic              full;

  // Counters.
  logic [15:0] next_inode_r, next_device_r;
  logic [15:0] inc_ino, fresh_ino, fresh_dev;
  logic        take;

  // Memories.
  logic [ENT_AW-1:0] base, ent_raddr, ent_waddr;
  logic              ent_we, fill_we;
  logic [ENT_W-1:0]  ent_rdata, ent_wdata;
  logic [BKT_W-1:0]  fill_waddr;
  logic [CNT_W-1:0]  fill_wdata, fill_rdata;

  // Output register.
  logic [15:0] short_dev_r, short_ino_r;
  logic        seen_r, status_r;

  assign hash_x  = dev_r ^ ino_r;
  assign qm_full = 16'(prod_r[HASH_SHIFT +: 8]) * 16'(HASH_MOD);

  // Quotient estimate is exact or one low, so the raw remainder stays below
  // twice the modulus and fits eight bits.
  always_comb begin
    red = (rraw_r >= 8'(HASH_MOD)) ? 7'(rraw_r - 8'(HASH_MOD)) : rraw_r[6:0];
    for (int i = 0; i < RED_STEPS; i++) begin
      if (int'(red) >= BUCKETS) begin
        red = red - 7'(BUCKETS);
      end
    end
    bucket_nxt = BKT_W'(red);
  end

  always_ff @(posedge clk) begin
    prod_r   <= 64'(hash_x) * 64'(HASH_RECIP);
    rraw_r   <= hash_x[7:0] - qm_full[7:0];
    bucket_r <= bucket_nxt;
  end

  // Fresh compact pair.
  always_comb begin
    inc_ino = next_inode_r + 16'd1;
    if (inc_ino == INO_LIMIT) begin
      fresh_ino = INO_RESTART;
      fresh_dev = next_device_r + 16'd1;
    end else begin
      fresh_ino = inc_ino;
      fresh_dev = next_device_r;
    end
  end

  assign full  = (fill_r == CNT_W'(WAYS));
  assign take  = !multi_r || !hit_r;
  assign base  = ENT_AW'(bucket_r) * ENT_AW'(WAYS);
  assign ent_raddr = base + ENT_AW'(way_r);
  assign ent_waddr = base + ENT_AW'(fill_r);
  assign ent_we    = cmd.finish && multi_r && !hit_r && !full;
  assign ent_wdata = {dev_r, ino_r, fresh_dev, fresh_ino};

  assign fill_we    = cmd.clr_step || ent_we;
  assign fill_waddr = cmd.clr_step ? clr_idx_r : bucket_r;
  assign clr_dummy  = '0;
  assign fill_wdata = cmd.clr_step ? clr_dummy : fill_r + CNT_W'(1);

  assign sts.multi_in  = (link_count > 16'd1);
  assign sts.clr_last  = (clr_idx_r == BKT_W'(BUCKETS - 1));
  assign sts.ways_done = (way_r == fill_r);
  assign sts.key_match = (ent_rdata[ENT_W-1:PAIR_W] == {dev_r, ino_r});

  fic_ram #(.WIDTH(ENT_W), .DEPTH(BUCKETS * WAYS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (cmd.way_rd),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  fic_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (cmd.fill_rd),
    .raddr (bucket_r),
    .rdata (fill_rdata)
  );

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_inode_r  <= 16'd1;
      next_device_r <= 16'd1;
      clr_idx_r     <= '0;
    end else begin
      if (cmd.clr_step && !sts.clr_last) begin
        clr_idx_r <= clr_idx_r + BKT_W'(1);
      end
      if (cmd.finish && take) begin
        next_inode_r  <= fresh_ino;
        next_device_r <= fresh_dev;
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dev_r   <= long_dev;
      ino_r   <= long_ino;
      multi_r <= sts.multi_in;
      hit_r   <= 1'b0;
    end
    if (cmd.fill_cap) begin
      fill_r <= fill_rdata;
      way_r  <= '0;
    end
    if (cmd.way_cmp) begin
      if (sts.key_match) begin
        hit_r      <= 1'b1;
        hit_pair_r <= ent_rdata[PAIR_W-1:0];
      end else begin
        way_r <= way_r + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      short_dev_r <= take ? fresh_dev : hit_pair_r[31:16];
      short_ino_r <= take ? fresh_ino : hit_pair_r[15:0];
      seen_r      <= multi_r && hit_r;
      status_r    <= multi_r && !hit_r && full;
    end
  end

  assign short_dev   = short_dev_r;
  assign short_ino   = short_ino_r;
  assign seen_before = seen_r;
  assign status      = status_r;

endmodule

/* rtl/core/fic_ctrl.sv */
// Controller state machine: table clearing, hash wait, way scan and result hand-off.
`timescale 1ns / 1ps

module fic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fic_pkg::fic_sts_t sts,
  output fic_pkg::fic_cmd_t cmd
);
  import fic_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_HASH3,
    S_FILL_RD,
    S_FILL_WAIT,
    S_WAY_RD,
    S_WAY_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.multi_in ? S_HASH1 : S_FIN;
        end
      end
      S_HASH1:   state_nxt = S_HASH2;
      S_HASH2:   state_nxt = S_HASH3;
      S_HASH3:   state_nxt = S_FILL_RD;
      S_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        cmd.fill_cap = 1'b1;
        state_nxt    = S_WAY_RD;
      end
      S_WAY_RD: begin
        if (sts.ways_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.way_rd = 1'b1;
          state_nxt  = S_WAY_CMP;
        end
      end
      S_WAY_CMP: begin
        cmd.way_cmp = 1'b1;
        state_nxt   = sts.key_match ? S_FIN : S_WAY_RD;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/file_id_compactor_unit.sv */
// Top level of the file ID compactor: maps 32-bit device/inode pairs to compact 16-bit pairs.
`timescale 1ns / 1ps

// The unit takes one file per input transfer (link count, 32-bit device and
// inode) and returns one result transfer with a compact 16-bit device and
// inode pair. Files with at most one link always get the next pair from the
// counters. Files with two or more links go through the hash pipeline
// (product, raw remainder and bucket registers) to pick a bucket, a read of
// that bucket's fill count, and then a scan of the filled ways through the
// single read port of the entry RAM, each way read and then compared. A hit
// ends the scan; a miss compares every filled way, at most WAYS. Items are
// handled one at a time, but a finished result sits in its own output
// register, so the next file is accepted while the previous result waits.
// After reset the unit clears the per-bucket fill counts and accepts no
// input during that pass. A miss in a full bucket still consumes a fresh
// pair but is not stored, and reports status = 1.
module file_id_compactor_unit #(
  parameter int BUCKETS = 128,
  parameter int WAYS    = 4
) (
  input logic        clk,
  input logic        rst_n,
  fic_in_if.sink     in_if,
  fic_out_if.source  out_if
);
  import fic_pkg::*;

  fic_cmd_t cmd;
  fic_sts_t sts;

  // The controller sequences the clearing pass and each item; it owns the
  // handshake signals of both channels.
  fic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the counters, the hash, the table RAMs and the
  // result register that drives the output payload.
  fic_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .link_count  (in_if.link_count),
    .long_dev    (in_if.long_dev),
    .long_ino    (in_if.long_ino),
    .cmd         (cmd),
    .sts         (sts),
    .short_dev   (out_if.short_dev),
    .short_ino   (out_if.short_ino),
    .seen_before (out_if.seen_before),
    .status      (out_if.status)
  );

  `include "assert_macros.svh"

  // A hit never reports a full bucket.
  `ASSERT_IMPLIES(a_seen_excludes_full, out_if.valid, !(out_if.seen_before && out_if.status))
  // No input is taken while the table is being cleared.
  `ASSERT_IMPLIES(a_no_accept_in_clear, cmd.clr_step, !in_if.ready)
  // A new result never overwrites one that has not been transferred.
  `ASSERT_IMPLIES(a_finish_slot_free, cmd.finish, !out_if.valid || out_if.ready)
  // Every finished item shows up on the result channel.
  `ASSERT_NEXT(a_finish_shows, cmd.finish, out_if.valid)

endmodule

/* sim/tb_file_id_compactor_unit.sv */
// Self-checking testbench for the file ID compactor top level.
`timescale 1ns / 1ps

module tb_file_id_compactor_unit;
  import fic_pkg::*;

  // Table geometry; the unit is built with the same values.
  localparam int BUCKETS = 128;
  localparam int WAYS    = 4;
  localparam int ENTRIES = BUCKETS * WAYS;

  // Timeout in clock cycles. About 700 files, each taking at worst the longest
  // lookup plus idle stretches on both sides, fit well inside this limit, so
  // it is several times what a correct unit needs.
  localparam int CYCLE_LIMIT = 200_000;

  // Largest multiplier k such that bucket + 103 * k fits in 32 bits for every bucket below 103.
  localparam longint unsigned HASH_STEPS_MAX = 64'd41698710;

  // One expected or observed result transfer.
  typedef struct packed {
    logic [15:0] short_dev;
    logic [15:0] short_ino;
    logic        seen_before;
    logic        status;
  } fic_result_t;

  logic clk;
  logic rst_n;

  fic_in_if  in_ch ();
  fic_out_if out_ch ();

  file_id_compactor_unit #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // Mirror of the unit's state: the two pair counters and the hashed table.
  logic [15:0] last_ino;
  logic [15:0] last_dev;
  logic        mapped_valid [ENTRIES];
  logic [63:0] mapped_key   [ENTRIES];
  logic [31:0] mapped_pair  [ENTRIES];

  // Results still owed by the unit, oldest first.
  fic_result_t pending_results[$];

  // Multi-link keys already offered; replaying them produces table hits.
  logic [63:0] known_keys[$];

  // When clear, neither the sender nor the receiver inserts idle cycles.
  bit idling_on;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int ready_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hands out the next compact pair. The inode counter skips 0xffff by
  // restarting at two, and each restart bumps the device counter.
  function automatic logic [31:0] take_next_pair();
    logic [15:0] n;
    n = last_ino + 16'd1;
    if (n == INO_LIMIT) begin
      n = INO_RESTART;
      last_dev = last_dev + 16'd1;
    end
    last_ino = n;
    return {last_dev, last_ino};
  endfunction

  // Works out the result for one accepted file and updates the mirrored state.
  // Files with zero or one link never touch the table. Multi-link files hit on
  // a matching valid way; a miss takes a fresh pair and stores it in the first
  // free way, or reports status when all ways are already taken.
  function automatic fic_result_t map_file_id(input logic [15:0] links,
                                              input logic [31:0] dev,
                                              input logic [31:0] ino);
    fic_result_t r;
    logic [63:0] key;
    int          base;
    int          free_way;
    bit          hit;
    r        = '0;
    key      = {dev, ino};
    base     = int'(((dev ^ ino) % HASH_MOD) % BUCKETS) * WAYS;
    free_way = WAYS;
    hit      = 1'b0;
    if (links <= 16'd1) begin
      {r.short_dev, r.short_ino} = take_next_pair();
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (mapped_valid[base + w]) begin
          if (!hit && mapped_key[base + w] == key) begin
            hit = 1'b1;
            {r.short_dev, r.short_ino} = mapped_pair[base + w];
          end
        end else if (free_way == WAYS) begin
          free_way = w;
        end
      end
      if (hit) begin
        r.seen_before = 1'b1;
      end else begin
        {r.short_dev, r.short_ino} = take_next_pair();
        if (free_way < WAYS) begin
          mapped_valid[base + free_way] = 1'b1;
          mapped_key[base + free_way]   = key;
          mapped_pair[base + free_way]  = {r.short_dev, r.short_ino};
        end else begin
          r.status = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Builds a random {dev, ino} key whose hash lands in the given bucket.
  function automatic logic [63:0] key_in_bucket(input int bucket);
    logic [31:0]     dev;
    longint unsigned steps;
    logic [31:0]     folded;
    dev    = $urandom;
    steps  = longint'($urandom) % (HASH_STEPS_MAX + 1);
    folded = 32'(longint'(bucket) + longint'(HASH_MOD) * steps);
    return {dev, dev ^ folded};
  endfunction

  // Link count for a multi-link file, with the extremes favored.
  function automatic logic [15:0] pick_links();
    unique case ($urandom_range(0, 3))
      0:       return 16'd2;
      1:       return 16'hffff;
      default: return 16'($urandom_range(2, 65535));
    endcase
  endfunction

  // Offers one file and returns at the edge where the transfer happens,
  // leaving valid high so that back-to-back files need no dead cycle.
  task automatic send_file(input logic [15:0] links, input logic [63:0] key);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.link_count <= links;
    in_ch.long_dev   <= key[63:32];
    in_ch.long_ino   <= key[31:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(map_file_id(links, key[63:32], key[31:0]));
    if (links >= 16'd2) begin
      known_keys.push_back(key);
      if (known_keys.size() > 200) void'(known_keys.pop_front());
    end
  endtask

  // Drops valid and holds off until every owed result has arrived.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Hand-picked files: counter paths with zero and one link, field extremes,
  // a miss followed by hits, a bucket filled way by way until it overflows,
  // hits on the first and the last way of a full bucket, and stored keys that
  // come back with too few links to use the table.
  task automatic test_directed_cases();
    logic [63:0] edge_keys [5];
    logic [63:0] zero_keys [3];
    for (int i = 0; i < 5; i++) edge_keys[i] = key_in_bucket(HASH_MOD - 1);
    for (int i = 0; i < 3; i++) zero_keys[i] = key_in_bucket(0);
    send_file(16'd0,     64'h0);
    send_file(16'd1,     {32'hffff_ffff, 32'hffff_ffff});
    send_file(16'd2,     64'h0);
    send_file(16'hffff,  64'h0);
    send_file(16'd2,     {32'hffff_ffff, 32'hffff_ffff});
    send_file(16'd7,     {32'hffff_ffff, 32'h0000_0000});
    send_file(16'h5555,  {32'haaaa_aaaa, 32'h5555_5555});
    send_file(16'haaaa,  {32'h5555_5555, 32'haaaa_aaaa});
    for (int i = 0; i < 4; i++) send_file(16'(2 + i), edge_keys[i]);
    // The fifth key finds every way taken, and again when it comes back.
    send_file(16'd5,     edge_keys[4]);
    send_file(16'd6,     edge_keys[4]);
    send_file(16'd9,     edge_keys[3]);
    send_file(16'd2,     edge_keys[0]);
    send_file(16'd0,     edge_keys[1]);
    send_file(16'd1,     64'h0);
    send_file(16'h8000,  {32'hffff_ffff, 32'hffff_ffff});
    // Bucket zero already holds two files; two more fill it and one overflows.
    for (int i = 0; i < 3; i++) send_file(16'h7fff, zero_keys[i]);
    send_file(16'hffff,  64'h0);
  endtask

  // Mostly well-formed traffic: replays of known multi-link files for hits,
  // new files steered into a few hot buckets so that they fill and overflow,
  // files with zero or one link, and fully random keys as noise. Idling is
  // switched on and off in stretches, and halfway through the sender waits
  // for the unit to drain completely.
  task automatic test_random_traffic(input int n_items);
    int          hot [6];
    int          pick;
    logic [15:0] links;
    logic [63:0] key;
    for (int i = 0; i < 6; i++) hot[i] = $urandom_range(0, HASH_MOD - 1);
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        idling_on = ($urandom_range(0, 3) != 0);
        hot[$urandom_range(0, 5)] = $urandom_range(0, HASH_MOD - 1);
      end
      if (i == n_items / 2) wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        links = 16'($urandom_range(0, 1));
        if (pick < 5 && known_keys.size() != 0)
          key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else
          key = {$urandom, $urandom};
      end else if (pick < 50 && known_keys.size() != 0) begin
        links = pick_links();
        key   = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (pick < 80) begin
        links = pick_links();
        key   = key_in_bucket(hot[$urandom_range(0, 5)]);
      end else begin
        links = pick_links();
        key   = {$urandom, $urandom};
      end
      send_file(links, key);
    end
  endtask

  // Closing stretch with idling switched off on both sides: files with zero
  // to three links, every third one a replay of a known file, back to back.
  task automatic test_busy_tail(input int n_items);
    logic [63:0] key;
    idling_on = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 3 == 0 && known_keys.size() != 0)
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else
        key = {$urandom, $urandom};
      send_file(16'($urandom_range(0, 3)), key);
    end
  endtask

  task automatic note_mismatch(input string what, input fic_result_t want,
                               input fic_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected dev=%h ino=%h seen=%b status=%b, got dev=%h ino=%h seen=%b status=%b",
               what, want.short_dev, want.short_ino, want.seen_before, want.status,
               got.short_dev, got.short_ino, got.seen_before, got.status);
  endtask

  // Receiver: ready toggles in random stretches; low stretches disappear once
  // idling is switched off.
  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (idling_on && $urandom_range(0, 2) == 0) begin
      out_ch.ready <= 1'b0;
      ready_left   <= $urandom_range(0, 12);
    end else begin
      out_ch.ready <= 1'b1;
      ready_left   <= $urandom_range(0, 15);
    end
  end

  // Every result transfer is checked field by field against the oldest owed
  // result. Outputs are sampled at the edge, before the unit's own updates.
  always @(posedge clk) begin
    fic_result_t got;
    fic_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.short_dev, out_ch.short_ino, out_ch.seen_before, out_ch.status};
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.short_dev !== want.short_dev || got.short_ino !== want.short_ino ||
            got.seen_before !== want.seen_before || got.status !== want.status)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.link_count = '0;
    in_ch.long_dev   = '0;
    in_ch.long_ino   = '0;
    idling_on        = 1'b1;
    last_ino         = 16'd1;
    last_dev         = 16'd1;
    for (int e = 0; e < ENTRIES; e++) mapped_valid[e] = 1'b0;

    // The unit clears its bucket fill counts after reset and holds ready low
    // meanwhile; the first send simply waits for it.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    wait_results_drained();
    test_random_traffic(620);
    wait_results_drained();
    test_busy_tail(60);
    wait_results_drained();

    // Allow for any stray late transfer, such as one from the slowest lookup.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/fic_pkg.sv
rtl/core/fic_ifs.sv
rtl/core/fic_ram.sv
rtl/core/fic_dp.sv
rtl/core/fic_ctrl.sv
rtl/core/file_id_compactor_unit.sv
sim/tb_file_id_compactor_unit.sv
